// ===== rtl/core/fsp_pkg.sv =====
package fsp_pkg;

  // accumulator width; values saturate at 2^NUM_BITS - 1 (range 8..31)
  localparam int NUM_BITS = 16;
  localparam int FIELD_W  = 16;

  typedef logic [NUM_BITS-1:0] acc_t;
  typedef logic [FIELD_W-1:0]  field_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_FLAGS   = 3'd1,
    PH_WIDTH   = 3'd2,
    PH_DOT     = 3'd3,
    PH_PSTART  = 3'd4,
    PH_PDIGITS = 3'd5,
    PH_LENGTH  = 3'd6,
    PH_CONV    = 3'd7
  } phase_t;

  // flag bit positions
  localparam int FB_SPACE = 0;
  localparam int FB_MINUS = 1;
  localparam int FB_PLUS  = 2;
  localparam int FB_HASH  = 3;
  localparam int FB_ZERO  = 4;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_LOW_H = 8'h68;
  localparam logic [7:0] CH_LOW_L = 8'h6C;
  localparam logic [7:0] CH_UP_L  = 8'h4C;

  localparam logic [1:0] LEN_NONE = 2'd0;
  localparam logic [1:0] LEN_H    = 2'd1;
  localparam logic [1:0] LEN_L    = 2'd2;
  localparam logic [1:0] LEN_BIGL = 2'd3;

  localparam logic [3:0] SPEC_NONE = 4'd0;

  typedef struct packed {
    phase_t     phase;
    logic [4:0] flags;
    acc_t       width_acc;
    acc_t       prec_acc;
    logic       dot_seen;
    logic [1:0] length_seen;
  } fsp_state_t;

  typedef struct packed {
    logic [3:0] spec_code;
    logic [1:0] length_code;
    logic       left_align;
    logic       force_sign;
    logic       space_sign;
    logic       alt_form;
    logic       zero_pad;
    field_t     field_width;
    field_t     precision;
    logic       has_dot;
    logic       end_consumed;
  } fsp_result_t;

  function automatic logic [4:0] flag_of(input logic [7:0] c);
    logic [4:0] f;
    f = '0;
    case (c)
      CH_SPACE: f[FB_SPACE] = 1'b1;
      CH_MINUS: f[FB_MINUS] = 1'b1;
      CH_PLUS:  f[FB_PLUS]  = 1'b1;
      CH_HASH:  f[FB_HASH]  = 1'b1;
      CH_ZERO:  f[FB_ZERO]  = 1'b1;
      default:  f = '0;
    endcase
    return f;
  endfunction

  function automatic logic [1:0] length_of(input logic [7:0] c);
    logic [1:0] l;
    case (c)
      CH_LOW_H: l = LEN_H;
      CH_LOW_L: l = LEN_L;
      CH_UP_L:  l = LEN_BIGL;
      default:  l = LEN_NONE;
    endcase
    return l;
  endfunction

  // c d e E f g G o s u x X p -> 1..13
  function automatic logic [3:0] conv_of(input logic [7:0] c);
    logic [3:0] s;
    case (c)
      8'h63:   s = 4'd1;
      8'h64:   s = 4'd2;
      8'h65:   s = 4'd3;
      8'h45:   s = 4'd4;
      8'h66:   s = 4'd5;
      8'h67:   s = 4'd6;
      8'h47:   s = 4'd7;
      8'h6F:   s = 4'd8;
      8'h73:   s = 4'd9;
      8'h75:   s = 4'd10;
      8'h78:   s = 4'd11;
      8'h58:   s = 4'd12;
      8'h70:   s = 4'd13;
      default: s = SPEC_NONE;
    endcase
    return s;
  endfunction

  function automatic logic is_numeral(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // acc * 10 + digit, saturating
  function automatic acc_t push_digit(input acc_t acc, input logic [7:0] c);
    logic [NUM_BITS+3:0] w;
    logic [NUM_BITS+3:0] v;
    logic [7:0]          d;
    w = (NUM_BITS+4)'(acc);
    d = c - CH_ZERO;
    v = (w << 3) + (w << 1) + (NUM_BITS+4)'(d[3:0]);
    return (v[NUM_BITS+3:NUM_BITS] != '0) ? '1 : v[NUM_BITS-1:0];
  endfunction

  function automatic acc_t sat_mag(input logic [31:0] m);
    return (m[31:NUM_BITS] != '0) ? '1 : m[NUM_BITS-1:0];
  endfunction

  function automatic field_t to_field(input acc_t acc);
    logic [31:0] w;
    w = 32'(acc);
    return w[FIELD_W-1:0];
  endfunction

endpackage

// ===== rtl/core/fsp_in_if.sv =====
interface fsp_in_if;
  logic               valid;
  logic               ready;
  logic [7:0]         ch;
  logic signed [31:0] star_arg;

  modport source (output valid, ch, star_arg, input ready);
  modport sink   (input valid, ch, star_arg, output ready);
endinterface

// ===== rtl/core/fsp_out_if.sv =====
interface fsp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  spec_code;
  logic [1:0]  length_code;
  logic        left_align;
  logic        force_sign;
  logic        space_sign;
  logic        alt_form;
  logic        zero_pad;
  logic [15:0] field_width;
  logic [15:0] precision;
  logic        has_dot;
  logic        end_consumed;

  modport source (output valid, spec_code, length_code, left_align, force_sign, space_sign,
                  alt_form, zero_pad, field_width, precision, has_dot, end_consumed,
                  input ready);
  modport sink   (input valid, spec_code, length_code, left_align, force_sign, space_sign,
                  alt_form, zero_pad, field_width, precision, has_dot, end_consumed,
                  output ready);
endinterface

// ===== rtl/core/format_specifier_parser.sv =====
// an ending character's result is registered in the output slot, or in the skid slot
// throughput: one character per cycle while the skid slot is empty, set by the
//   combinational phase cascade and the multiply-by-ten digit accumulator
// a two-entry output buffer lets characters keep flowing while one result is stalled
// reset (rst_n low, synchronous): parser returns to idle, fields cleared, buffers empty
module format_specifier_parser (
  input  logic      clk,
  input  logic      rst_n,
  fsp_in_if.sink    in_chan,
  fsp_out_if.source out_chan
);
  import fsp_pkg::*;

  fsp_state_t  state_r, state_nxt;
  fsp_result_t step_res;
  logic        step_emit;

  fsp_result_t out_data_r, out_data_nxt;
  fsp_result_t skid_data_r, skid_data_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        skid_valid_r, skid_valid_nxt;

  logic accept, pop, push;

  fsp_step u_step (
    .cur      (state_r),
    .ch       (in_chan.ch),
    .star_arg (in_chan.star_arg),
    .nxt      (state_nxt),
    .emit     (step_emit),
    .res      (step_res)
  );

  assign in_chan.ready = !skid_valid_r;
  assign accept        = in_chan.valid && in_chan.ready;
  assign pop           = out_valid_r && out_chan.ready;
  assign push          = accept && step_emit;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      // no new transaction while the skid slot is occupied
      if (pop) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (!out_valid_r || pop) begin
      out_valid_nxt = push;
      if (push) out_data_nxt = step_res;
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = step_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (accept) state_r <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.spec_code    = out_data_r.spec_code;
  assign out_chan.length_code  = out_data_r.length_code;
  assign out_chan.left_align   = out_data_r.left_align;
  assign out_chan.force_sign   = out_data_r.force_sign;
  assign out_chan.space_sign   = out_data_r.space_sign;
  assign out_chan.alt_form     = out_data_r.alt_form;
  assign out_chan.zero_pad     = out_data_r.zero_pad;
  assign out_chan.field_width  = out_data_r.field_width;
  assign out_chan.precision    = out_data_r.precision;
  assign out_chan.has_dot      = out_data_r.has_dot;
  assign out_chan.end_consumed = out_data_r.end_consumed;

endmodule

// ===== rtl/core/fsp_step.sv =====
module fsp_step (
  input  fsp_pkg::fsp_state_t  cur,
  input  logic [7:0]           ch,
  input  logic [31:0]          star_arg,
  output fsp_pkg::fsp_state_t  nxt,
  output logic                 emit,
  output fsp_pkg::fsp_result_t res
);
  import fsp_pkg::*;

  logic        neg;
  logic [31:0] mag;
  logic [4:0]  fl;
  logic [1:0]  len;
  logic [3:0]  spec;
  logic [4:0]  fb;

  assign neg  = star_arg[31];
  assign mag  = neg ? (~star_arg + 32'd1) : star_arg;
  assign fl   = flag_of(ch);
  assign len  = length_of(ch);
  assign spec = conv_of(ch);

  // phase cascade: a character may fall through several empty phases
  always_comb begin
    phase_t ph;
    logic   hit;
    nxt  = cur;
    emit = 1'b0;
    hit  = 1'b0;
    ph   = cur.phase;
    fb   = cur.flags;
    res  = '0;

    if (ph == PH_IDLE) begin
      nxt       = '0;
      nxt.phase = PH_FLAGS;
      hit       = 1'b1;
    end
    if (!hit && ph == PH_FLAGS) begin
      if (fl != '0) begin
        nxt.flags = cur.flags | fl;
        hit       = 1'b1;
      end else begin
        ph = PH_WIDTH;
      end
    end
    if (!hit && ph == PH_WIDTH) begin
      if (ch == CH_STAR && cur.width_acc == '0) begin
        if (neg) nxt.flags[FB_MINUS] = 1'b1;
        nxt.width_acc = sat_mag(mag);
        nxt.phase     = PH_DOT;
        hit           = 1'b1;
      end else if (is_numeral(ch)) begin
        nxt.width_acc = push_digit(cur.width_acc, ch);
        nxt.phase     = PH_WIDTH;
        hit           = 1'b1;
      end else begin
        ph = PH_DOT;
      end
    end
    if (!hit && ph == PH_DOT) begin
      if (ch == CH_DOT) begin
        nxt.dot_seen = 1'b1;
        nxt.phase    = PH_PSTART;
        hit          = 1'b1;
      end else begin
        ph = PH_LENGTH;
      end
    end
    if (!hit && ph == PH_PSTART) begin
      if (ch == CH_STAR) begin
        if (!neg && star_arg != '0) nxt.prec_acc = sat_mag(mag);
        nxt.phase = PH_LENGTH;
        hit       = 1'b1;
      end else if (is_numeral(ch)) begin
        nxt.prec_acc = push_digit(cur.prec_acc, ch);
        nxt.phase    = PH_PDIGITS;
        hit          = 1'b1;
      end else begin
        ph = PH_LENGTH;
      end
    end
    if (!hit && ph == PH_PDIGITS) begin
      if (is_numeral(ch)) begin
        nxt.prec_acc = push_digit(cur.prec_acc, ch);
        hit          = 1'b1;
      end else begin
        ph = PH_LENGTH;
      end
    end
    if (!hit && ph == PH_LENGTH) begin
      if (len != LEN_NONE) begin
        nxt.length_seen = len;
        nxt.phase       = PH_CONV;
        hit             = 1'b1;
      end
    end

    if (!hit) begin
      if (fb[FB_PLUS])  fb[FB_SPACE] = 1'b0;
      if (fb[FB_MINUS]) fb[FB_ZERO]  = 1'b0;
      emit             = 1'b1;
      res.spec_code    = spec;
      res.length_code  = cur.length_seen;
      res.left_align   = fb[FB_MINUS];
      res.force_sign   = fb[FB_PLUS];
      res.space_sign   = fb[FB_SPACE];
      res.alt_form     = fb[FB_HASH];
      res.zero_pad     = fb[FB_ZERO];
      res.field_width  = to_field(cur.width_acc);
      res.precision    = to_field(cur.prec_acc);
      res.has_dot      = cur.dot_seen;
      res.end_consumed = (spec != SPEC_NONE);
      nxt              = '0;
      nxt.phase        = PH_IDLE;
    end
  end

endmodule

// ===== rtl/core/fsp_checker.sv =====
module fsp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  spec_code,
  input logic [1:0]  length_code,
  input logic        left_align,
  input logic        force_sign,
  input logic        space_sign,
  input logic        zero_pad,
  input logic [15:0] field_width,
  input logic [15:0] precision,
  input logic        has_dot,
  input logic        end_consumed
);
  import fsp_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(spec_code) && $stable(length_code)
      && $stable(field_width) && $stable(precision) && $stable(end_consumed))
    else $error("result changed while stalled");

  // the ending character is consumed exactly when it is a conversion letter
  a_consumed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (end_consumed == (spec_code != SPEC_NONE)) && (spec_code <= 4'd13))
    else $error("end_consumed disagrees with spec_code");

  // flag conflicts resolved
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(zero_pad && left_align) && !(space_sign && force_sign))
    else $error("unresolved flag conflict");

  // precision only with a dot
  a_prec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !has_dot |-> precision == '0)
    else $error("precision without dot");

endmodule

bind format_specifier_parser fsp_checker u_fsp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .spec_code    (out_chan.spec_code),
  .length_code  (out_chan.length_code),
  .left_align   (out_chan.left_align),
  .force_sign   (out_chan.force_sign),
  .space_sign   (out_chan.space_sign),
  .zero_pad     (out_chan.zero_pad),
  .field_width  (out_chan.field_width),
  .precision    (out_chan.precision),
  .has_dot      (out_chan.has_dot),
  .end_consumed (out_chan.end_consumed)
);
